// ===== rtl/ucri_pkg.sv =====
// ----------------------------------------------------------------------------
// ucri_pkg
// Shared types, widths and helpers for the unit cylinder line intersector.
// ----------------------------------------------------------------------------
package ucri_pkg;

  localparam int FIELD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int MAG_W         = 2 * FIELD_W;   // coefficient magnitudes
  localparam int SQR_W         = 2 * MAG_W;     // discriminant
  localparam int QDEPTH        = 4;

  typedef logic signed [FIELD_W-1:0] fld_t;
  typedef logic [2:0][FIELD_W-1:0]   vec3_t;    // [0]=x [1]=y [2]=z

  typedef struct packed {
    fld_t origin_x;
    fld_t origin_y;
    fld_t origin_z;
    fld_t dir_x;
    fld_t dir_y;
    fld_t dir_z;
  } in_item_t;

  typedef struct packed {
    logic hit;
    fld_t enter_x;
    fld_t enter_y;
    fld_t enter_z;
    fld_t exit_x;
    fld_t exit_y;
    fld_t exit_z;
  } out_item_t;

  // Per-ray context carried from classification to the point stages
  typedef struct packed {
    logic             hit;
    vec3_t            p;
    vec3_t            d;
    logic [MAG_W-1:0] a;
    logic             bh_pos;   // B > 0, picks root sign
    logic [MAG_W-1:0] bh_mag;
    logic             c_neg;
    logic [MAG_W-1:0] c_mag;
  } ray_ctx_t;

  typedef struct packed {
    ray_ctx_t         ctx;
    logic [SQR_W-1:0] disc;
  } q_entry_t;

  function automatic logic [2*FIELD_W-1:0] umul32(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b);
    logic [2*FIELD_W-1:0] r;
    r = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
    return r;
  endfunction

  function automatic logic signed [2*FIELD_W-1:0] smul32(input logic signed [FIELD_W-1:0] a,
                                                         input logic signed [FIELD_W-1:0] b);
    logic signed [2*FIELD_W-1:0] r;
    r = a * b;
    return r;
  endfunction

endpackage

// ===== rtl/ucri_if.sv =====
// ----------------------------------------------------------------------------
// ucri_in_if / ucri_out_if
// Valid/ready channels for rays in and intersection results out.
// ----------------------------------------------------------------------------
interface ucri_in_if;
  import ucri_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ucri_out_if;
  import ucri_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ucri_front.sv =====
// ----------------------------------------------------------------------------
// ucri_front
// Forms A, B/2, C and the discriminant; classifies hit / no hit.
// ----------------------------------------------------------------------------
module ucri_front import ucri_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ucri_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     push,
  output q_entry_t push_data
);

  localparam int BW = MAG_W + 1;

  logic       adv;
  logic [5:0] v_r;

  // stage 0: captured beat
  vec3_t s0_p_r, s0_d_r;
  // stage 1: products
  logic signed [MAG_W-1:0] s1_dx2_r, s1_dz2_r, s1_pxdx_r, s1_pzdz_r, s1_px2_r, s1_pz2_r;
  vec3_t s1_p_r, s1_d_r;
  // stage 2..5
  ray_ctx_t s2_ctx_r, s3_ctx_r, s4_ctx_r, s5_ctx_r;
  logic [MAG_W-1:0]   s3_bb_r [4];
  logic [MAG_W-1:0]   s3_ac_r [4];
  logic [SQR_W-1:0]   s4_bb_r, s4_ac_r;
  logic [SQR_W-1:0]   s5_disc_r;

  logic signed [BW-1:0] bh_w, c_w;
  ray_ctx_t             ctx2_w, ctx5_w;
  logic [SQR_W:0]       disc_w;

  assign adv         = !(v_r[5] && q_full);
  assign in_ch.ready = adv;
  assign push        = v_r[5] && !q_full;
  assign push_data   = '{ctx: s5_ctx_r, disc: s5_disc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_ch.valid};
    end
  end

  always_comb begin
    bh_w = BW'(s1_pxdx_r) + BW'(s1_pzdz_r);
    c_w  = BW'(s1_px2_r) + BW'(s1_pz2_r) - (BW'(1) << (2 * FRAC_BITS));
    ctx2_w        = '0;
    ctx2_w.p      = s1_p_r;
    ctx2_w.d      = s1_d_r;
    ctx2_w.a      = MAG_W'(s1_dx2_r) + MAG_W'(s1_dz2_r);
    ctx2_w.bh_pos = !bh_w[BW-1] && (bh_w != '0);
    ctx2_w.bh_mag = bh_w[BW-1] ? MAG_W'(-bh_w) : bh_w[MAG_W-1:0];
    ctx2_w.c_neg  = c_w[BW-1];
    ctx2_w.c_mag  = c_w[BW-1] ? MAG_W'(-c_w) : c_w[MAG_W-1:0];
  end

  // D = (B/2)^2 - A*C, hit when A != 0 and D >= 0
  always_comb begin
    disc_w = s4_ctx_r.c_neg ? ({1'b0, s4_bb_r} + {1'b0, s4_ac_r})
                            : ({1'b0, s4_bb_r} - {1'b0, s4_ac_r});
    ctx5_w     = s4_ctx_r;
    ctx5_w.hit = (s4_ctx_r.a != '0) && !disc_w[SQR_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p_r <= {in_ch.payload.origin_z, in_ch.payload.origin_y, in_ch.payload.origin_x};
      s0_d_r <= {in_ch.payload.dir_z, in_ch.payload.dir_y, in_ch.payload.dir_x};

      s1_dx2_r  <= smul32($signed(s0_d_r[0]), $signed(s0_d_r[0]));
      s1_dz2_r  <= smul32($signed(s0_d_r[2]), $signed(s0_d_r[2]));
      s1_pxdx_r <= smul32($signed(s0_p_r[0]), $signed(s0_d_r[0]));
      s1_pzdz_r <= smul32($signed(s0_p_r[2]), $signed(s0_d_r[2]));
      s1_px2_r  <= smul32($signed(s0_p_r[0]), $signed(s0_p_r[0]));
      s1_pz2_r  <= smul32($signed(s0_p_r[2]), $signed(s0_p_r[2]));
      s1_p_r    <= s0_p_r;
      s1_d_r    <= s0_d_r;

      s2_ctx_r <= ctx2_w;

      // 64x64 products as four 32x32 partials
      s3_bb_r[0] <= umul32(s2_ctx_r.bh_mag[FIELD_W-1:0], s2_ctx_r.bh_mag[FIELD_W-1:0]);
      s3_bb_r[1] <= umul32(s2_ctx_r.bh_mag[FIELD_W-1:0], s2_ctx_r.bh_mag[MAG_W-1:FIELD_W]);
      s3_bb_r[2] <= umul32(s2_ctx_r.bh_mag[MAG_W-1:FIELD_W], s2_ctx_r.bh_mag[FIELD_W-1:0]);
      s3_bb_r[3] <= umul32(s2_ctx_r.bh_mag[MAG_W-1:FIELD_W], s2_ctx_r.bh_mag[MAG_W-1:FIELD_W]);
      s3_ac_r[0] <= umul32(s2_ctx_r.a[FIELD_W-1:0], s2_ctx_r.c_mag[FIELD_W-1:0]);
      s3_ac_r[1] <= umul32(s2_ctx_r.a[FIELD_W-1:0], s2_ctx_r.c_mag[MAG_W-1:FIELD_W]);
      s3_ac_r[2] <= umul32(s2_ctx_r.a[MAG_W-1:FIELD_W], s2_ctx_r.c_mag[FIELD_W-1:0]);
      s3_ac_r[3] <= umul32(s2_ctx_r.a[MAG_W-1:FIELD_W], s2_ctx_r.c_mag[MAG_W-1:FIELD_W]);
      s3_ctx_r   <= s2_ctx_r;

      s4_bb_r  <= SQR_W'(s3_bb_r[0]) + ((SQR_W'(s3_bb_r[1]) + SQR_W'(s3_bb_r[2])) << FIELD_W)
                + (SQR_W'(s3_bb_r[3]) << MAG_W);
      s4_ac_r  <= SQR_W'(s3_ac_r[0]) + ((SQR_W'(s3_ac_r[1]) + SQR_W'(s3_ac_r[2])) << FIELD_W)
                + (SQR_W'(s3_ac_r[3]) << MAG_W);
      s4_ctx_r <= s3_ctx_r;

      s5_ctx_r  <= ctx5_w;
      s5_disc_r <= disc_w[SQR_W-1:0];
    end
  end

endmodule

// ===== rtl/ucri_queue.sv =====
// ----------------------------------------------------------------------------
// ucri_queue
// Short FIFO between classification and the root / point pipeline.
// ----------------------------------------------------------------------------
module ucri_queue import ucri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t head
);

  localparam int PW = $clog2(QDEPTH);

  q_entry_t        mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== rtl/ucri_back.sv =====
// ----------------------------------------------------------------------------
// ucri_back
// Square root and both root quotients one bit a stage, then the saturated points.
// ----------------------------------------------------------------------------
module ucri_back import ucri_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  q_entry_t    q_head,
  output logic        pop,
  ucri_out_if.source  out_ch
);

  localparam int SQ_N     = MAG_W;            // root bits
  localparam int SQ_RW    = MAG_W + 4;
  localparam int DV_W     = MAG_W + 2;        // divisor width
  localparam int DR_W     = DV_W + 1;
  localparam int QB       = MAG_W - 1;        // quotient bits, all ones = cap
  localparam int NUM_W    = DV_W + FRAC_BITS;
  localparam int CMP_W    = DV_W + QB;
  localparam int OUT_BITS = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int PROD_W   = FIELD_W + QB;
  localparam int SUM_W    = PROD_W + 2;
  localparam int NE       = 6;                // two points, three axes

  logic adv;
  logic out_valid_r;
  out_item_t out_data_r;

  assign adv           = !out_valid_r || out_ch.ready;
  assign pop           = adv && !q_empty;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.payload = out_data_r;

  // ---------------- square root, one bit per stage ----------------
  logic             sq_v_r    [SQ_N];
  ray_ctx_t         sq_ctx_r  [SQ_N];
  logic [SQR_W-1:0] sq_x_r    [SQ_N];
  logic [SQ_RW-1:0] sq_rem_r  [SQ_N];
  logic [MAG_W-1:0] sq_root_r [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic             vi;
    ray_ctx_t         ci;
    logic [SQR_W-1:0] xi;
    logic [SQ_RW-1:0] ri, rs, trial;
    logic [MAG_W-1:0] qi;
    if (k == 0) begin : g_first
      assign vi = !q_empty;
      assign ci = q_head.ctx;
      assign xi = q_head.disc;
      assign ri = '0;
      assign qi = '0;
    end else begin : g_rest
      assign vi = sq_v_r[k-1];
      assign ci = sq_ctx_r[k-1];
      assign xi = sq_x_r[k-1];
      assign ri = sq_rem_r[k-1];
      assign qi = sq_root_r[k-1];
    end
    assign rs    = {ri[SQ_RW-3:0], xi[2*(SQ_N-1-k)+1 -: 2]};
    assign trial = SQ_RW'({qi, 2'b01});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx_r[k] <= ci;
        sq_x_r[k]   <= xi;
        if (rs >= trial) begin
          sq_rem_r[k]  <= rs - trial;
          sq_root_r[k] <= {qi[MAG_W-2:0], 1'b1};
        end else begin
          sq_rem_r[k]  <= rs;
          sq_root_r[k] <= {qi[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- M = S + |B/2| ----------------
  logic            m_v_r;
  ray_ctx_t        m_ctx_r;
  logic [DV_W-1:0] m_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= sq_v_r[SQ_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ctx_r <= sq_ctx_r[SQ_N-1];
      m_val_r <= DV_W'(sq_root_r[SQ_N-1]) + DV_W'(sq_ctx_r[SQ_N-1].bh_mag);
    end
  end

  // ---------------- two restoring dividers in lockstep ----------------
  // lane 0: t0 = C*2^F / M, lane 1: t1 = M*2^F / A
  logic            dv_v_r   [QB+1];
  ray_ctx_t        dv_ctx_r [QB+1];
  logic            dv_mz_r  [QB+1];
  logic            dv_ov_r  [2][QB+1];
  logic [DR_W-1:0] dv_rem_r [2][QB+1];
  logic [QB-1:0]   dv_q_r   [2][QB+1];
  logic [QB-1:0]   dv_n_r   [2][QB+1];
  logic [DV_W-1:0] dv_d_r   [2][QB+1];

  logic [NUM_W-1:0] num_w [2];
  logic [DV_W-1:0]  den_w [2];

  assign num_w[0] = NUM_W'(m_ctx_r.c_mag) << FRAC_BITS;
  assign num_w[1] = NUM_W'(m_val_r) << FRAC_BITS;
  assign den_w[0] = m_val_r;
  assign den_w[1] = DV_W'(m_ctx_r.a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) dv_v_r[j] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= m_v_r;
      for (int j = 1; j <= QB; j++) dv_v_r[j] <= dv_v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx_r[0] <= m_ctx_r;
      dv_mz_r[0]  <= (m_val_r == '0);
      for (int j = 1; j <= QB; j++) begin
        dv_ctx_r[j] <= dv_ctx_r[j-1];
        dv_mz_r[j]  <= dv_mz_r[j-1];
      end
    end
  end

  for (genvar u = 0; u < 2; u++) begin : g_lane
    // quotient overflows the cap when num >= den * 2^QB
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ov_r[u][0]  <= (CMP_W'(num_w[u]) >= (CMP_W'(den_w[u]) << QB));
        dv_rem_r[u][0] <= DR_W'(num_w[u] >> QB);
        dv_q_r[u][0]   <= '0;
        dv_n_r[u][0]   <= num_w[u][QB-1:0];
        dv_d_r[u][0]   <= den_w[u];
      end
    end
    for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [DR_W-1:0] rs;
      logic [QB-1:0]   qn;
      assign rs = {dv_rem_r[u][j-1][DR_W-2:0], dv_n_r[u][j-1][QB-j]};
      always_comb begin
        qn         = dv_q_r[u][j-1];
        qn[QB-j]   = (rs >= DR_W'(dv_d_r[u][j-1]));
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_ov_r[u][j]  <= dv_ov_r[u][j-1];
          dv_rem_r[u][j] <= qn[QB-j] ? rs - DR_W'(dv_d_r[u][j-1]) : rs;
          dv_q_r[u][j]   <= qn;
          dv_n_r[u][j]   <= dv_n_r[u][j-1];
          dv_d_r[u][j]   <= dv_d_r[u][j-1];
        end
      end
    end
  end

  // ---------------- root parameters ----------------
  logic          t_v_r;
  ray_ctx_t      t_ctx_r;
  logic [QB-1:0] t_mag_r [2];
  logic          t_neg_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (adv) begin
      t_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ctx_r    <= dv_ctx_r[QB];
      t_mag_r[0] <= dv_mz_r[QB]    ? '0 :
                    dv_ov_r[0][QB] ? '1 : dv_q_r[0][QB];
      t_mag_r[1] <= dv_ov_r[1][QB] ? '1 : dv_q_r[1][QB];
      t_neg_r[0] <= dv_ctx_r[QB].bh_pos ^ dv_ctx_r[QB].c_neg;
      t_neg_r[1] <= dv_ctx_r[QB].bh_pos;
    end
  end

  // ---------------- points p + d*t ----------------
  logic                 c0_v_r, c1_v_r, c2_v_r;
  logic                 c0_hit_r, c1_hit_r, c2_hit_r;
  vec3_t                c0_p_r, c1_p_r;
  logic [2*FIELD_W-1:0] c0_lo_r [NE];
  logic [2*FIELD_W-1:0] c0_hi_r [NE];
  logic                 c0_neg_r [NE];
  logic [PROD_W-1:0]    c1_prod_r [NE];
  logic                 c1_neg_r  [NE];
  logic [SUM_W-1:0]     c2_sum_r  [NE];
  fld_t                 res_w     [NE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_v_r      <= 1'b0;
      c1_v_r      <= 1'b0;
      c2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      c0_v_r      <= t_v_r;
      c1_v_r      <= c0_v_r;
      c2_v_r      <= c1_v_r;
      out_valid_r <= c2_v_r;
    end
  end

  for (genvar e = 0; e < NE; e++) begin : g_pt
    localparam int U  = e / 3;
    localparam int AX = e % 3;
    logic signed [FIELD_W-1:0] dv;
    logic [FIELD_W-1:0]        dmag;
    logic [SUM_W-1:0]          ps, px;
    logic                      sneg;
    logic [SUM_W-1:0]          smag, mm, lim;
    assign dv   = $signed(t_ctx_r.d[AX]);
    assign dmag = dv[FIELD_W-1] ? FIELD_W'(-dv) : dv;
    assign ps   = SUM_W'($signed(c1_p_r[AX])) << FRAC_BITS;
    assign px   = SUM_W'(c1_prod_r[e]);
    assign sneg = c2_sum_r[e][SUM_W-1];
    assign smag = sneg ? (SUM_W'(0) - c2_sum_r[e]) : c2_sum_r[e];
    assign lim  = SUM_W'(1) << (OUT_BITS - 1);
    always_comb begin
      mm = smag >> FRAC_BITS;
      if (sneg) begin
        if (mm > lim) mm = lim;
        res_w[e] = FIELD_W'(SUM_W'(0) - mm);
      end else begin
        if (mm >= lim) mm = lim - 1'b1;
        res_w[e] = FIELD_W'(mm);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c0_lo_r[e]  <= umul32(dmag, t_mag_r[U][FIELD_W-1:0]);
        c0_hi_r[e]  <= umul32(dmag, FIELD_W'(t_mag_r[U][QB-1:FIELD_W]));
        c0_neg_r[e] <= dv[FIELD_W-1] ^ t_neg_r[U];
        c1_prod_r[e] <= PROD_W'(c0_lo_r[e]) + (PROD_W'(c0_hi_r[e]) << FIELD_W);
        c1_neg_r[e]  <= c0_neg_r[e];
        // negate-and-add in one adder via carry-in
        c2_sum_r[e]  <= ps + (c1_neg_r[e] ? ~px : px) + SUM_W'(c1_neg_r[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_hit_r <= t_ctx_r.hit;
      c0_p_r   <= t_ctx_r.p;
      c1_hit_r <= c0_hit_r;
      c1_p_r   <= c0_p_r;
      c2_hit_r <= c1_hit_r;
      out_data_r.hit     <= c2_hit_r;
      out_data_r.enter_x <= c2_hit_r ? res_w[0] : '0;
      out_data_r.enter_y <= c2_hit_r ? res_w[1] : '0;
      out_data_r.enter_z <= c2_hit_r ? res_w[2] : '0;
      out_data_r.exit_x  <= c2_hit_r ? res_w[3] : '0;
      out_data_r.exit_y  <= c2_hit_r ? res_w[4] : '0;
      out_data_r.exit_z  <= c2_hit_r ? res_w[5] : '0;
    end
  end

endmodule

// ===== rtl/unit_cylinder_ray_intersect.sv =====
// ----------------------------------------------------------------------------
// unit_cylinder_ray_intersect
// Intersects a fixed-point line with the radius-1 cylinder around the y axis.
// ----------------------------------------------------------------------------
// Takes one ray per beat and returns one result beat per ray, in order. The
// block is fully pipelined and sustains one ray per clock while output
// backpressure does not stall it. A ray passes through the front, the
// queue, the 64-stage square root, the M adder and the 64-stage dividers
// (an overflow test, then one quotient bit per stage), then the root
// register, the three point stages and the output register. A = dx^2+dz^2,
// B/2 = px*dx+pz*dz and C = px^2+pz^2-1 are formed exactly; a negative
// discriminant or A = 0 (line parallel to the axis) gives hit = 0 with all
// point fields zero. Otherwise the two roots use the cancellation-free form
// chosen by the sign of B, and enter/exit are the points for those roots in
// that order (not sorted). Coordinates carry FRAC_BITS fraction bits, are
// truncated toward zero and saturate to a signed WORD_BITS (max 32) word.
// A four-entry queue decouples classification from the root pipeline, so
// either side can stall on its own; output backpressure holds the back end.
// ----------------------------------------------------------------------------
module unit_cylinder_ray_intersect import ucri_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,   // 8..24
  parameter int WORD_BITS = WORD_BITS_DEF    // 16..40, output saturation width
) (
  input  logic       clk,
  input  logic       rst_n,
  ucri_in_if.sink    in_ch,
  ucri_out_if.source out_ch
);

  // front -> queue
  logic     push;
  q_entry_t push_data;
  logic     q_full;

  // queue -> back
  logic     pop;
  logic     q_empty;
  q_entry_t q_head;

  // classification: coefficients, discriminant, hit flag
  ucri_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ucri_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // sqrt, root quotients, point evaluation and output register
  ucri_back #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
